### design/sec_pkg.sv
// sec_pkg: shared types, constants and helper functions for the stereo
// EQ / echo / chorus block. No dependencies.
`default_nettype none

package sec_pkg;

  localparam int ECHO_SAMPLES_DEF  = 11025;
  localparam int SWEEP_SAMPLES_DEF = 2205;
  localparam int SINE_DEPTH_DEF    = 1024;

  localparam int LOW_WEIGHT   = 655;      // 0.01 in Q0.16
  localparam int TAP_BASE     = 200;      // fixed part of chorus tap delay
  localparam int DIV10_RECIP  = 6710887;  // ceil(2^26 / 10)
  localparam int DIV10_SHIFT  = 26;
  localparam int CLR_AW       = 16;       // covers the largest echo depth

  typedef struct packed {
    logic [15:0] bass_gain;
    logic [15:0] mid_gain;
    logic [15:0] treble_gain;
    logic [15:0] echo_mix;
    logic [15:0] echo_feedback;
    logic [19:0] lfo_step;
    logic [10:0] sweep_depth;
    logic [15:0] chorus_mix;
  } cfg_t;

  typedef enum logic [3:0] {
    REG_BASS_GAIN     = 4'd0,
    REG_MID_GAIN      = 4'd1,
    REG_TREBLE_GAIN   = 4'd2,
    REG_ECHO_MIX      = 4'd3,
    REG_ECHO_FEEDBACK = 4'd4,
    REG_LFO_STEP      = 4'd5,
    REG_SWEEP_DEPTH   = 4'd6,
    REG_CHORUS_MIX    = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic              en;
    logic [CLR_AW-1:0] addr;
  } clr_t;

  typedef struct packed {
    logic idle;
    logic done;
  } lane_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOW_MUL,
    ST_LOW_ADD,
    ST_HIGH_UPD,
    ST_BASS_MUL,
    ST_MID_MUL,
    ST_TREB_MUL,
    ST_EQ_SUM,
    ST_EQ_SAT,
    ST_ECHO_MIX,
    ST_ECHO_WR,
    ST_IDX_A,
    ST_LFO_A,
    ST_TAP_A,
    ST_IDX_B,
    ST_LFO_B,
    ST_TAP_B,
    ST_STEP_B,
    ST_CHOR_DRY,
    ST_CHOR_WET,
    ST_CHOR_SUM,
    ST_DONE
  } lane_state_t;

  // Saturate to signed 24-bit (Q16.8 sample range).
  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    logic signed [23:0] r;
    if (v > 64'sd8388607) r = 24'sd8388607;
    else if (v < -64'sd8388608) r = -24'sd8388608;
    else r = v[23:0];
    return r;
  endfunction

  // Quadrant polynomial sine of a turn fraction, Q1.15. Elaboration only.
  function automatic logic signed [15:0] sine_of(input logic [31:0] turn);
    longint unsigned z;
    longint unsigned z2;
    longint unsigned r;
    longint unsigned y;
    logic signed [15:0] res;
    z = longint'(turn[29:14]);
    if (turn[30]) z = 64'd65536 - z;
    z2 = (z * z) >> 16;
    r = 64'd41906 - ((64'd4569 * z2) >> 16);
    r = 64'd102873 - ((r * z2) >> 16);
    y = ((r * z) >> 16) >> 1;
    if (y > 64'd32767) y = 64'd32767;
    res = 16'(y);
    if (turn[31]) res = -res;
    return res;
  endfunction

endpackage

`default_nettype wire

### design/stereo_eq_reverb_chorus.sv
// stereo_eq_reverb_chorus: top level. Config registers, memory clearing,
// two channel lanes and the output merge stage. Uses sec_pkg, sec_lane.
//
// Usage:
//   s_axis: one beat per stereo frame, tdata = {right_in, left_in}.
//   m_axis: one beat per processed frame, tdata = {right_out, left_out}.
//   cfg: register writes (index, data), always ready; write only while idle.
// Both channels run in their own lane in lockstep; each lane steps one
// shared multiplier through the EQ, echo and chorus math in a chain of
// states, from the accepted input beat until the result is taken into the
// output register. A new frame is taken only once both lanes are back in
// idle, so a frame is not accepted while the previous one is in flight.
// Reset: registers go to their defaults, filters and LFOs restart, and the
// echo and chorus memories are swept to zero one entry per cycle over
// max(ECHO_SAMPLES, SWEEP_SAMPLES) entries (11025 by default); s_axis_tready
// stays low during that sweep, cfg writes are taken as usual.
// Stall: a result waiting in the output register does not block the lanes
// from taking the next frame; a finished frame waits in the lanes until
// the output register frees up, and input is held off meanwhile.
`default_nettype none

module stereo_eq_reverb_chorus #(
  parameter int ECHO_SAMPLES  = sec_pkg::ECHO_SAMPLES_DEF,
  parameter int SWEEP_SAMPLES = sec_pkg::SWEEP_SAMPLES_DEF,
  parameter int SINE_DEPTH    = sec_pkg::SINE_DEPTH_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [15:0] s_axis_tdata,   // [7:0] left_in, [15:8] right_in
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] left_out, [15:8] right_out
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [3:0]  cfg_index,
  input  wire  [19:0] cfg_data
);
  import sec_pkg::*;

  localparam int EW = (ECHO_SAMPLES > 1) ? $clog2(ECHO_SAMPLES) : 1;
  localparam int SW = $clog2(SWEEP_SAMPLES);
  localparam int CLR_DEPTH = (ECHO_SAMPLES > SWEEP_SAMPLES) ? ECHO_SAMPLES
                                                            : SWEEP_SAMPLES;
  localparam int CW = $clog2(CLR_DEPTH + 1);

  cfg_t        cfg;
  logic        clearing;
  logic [CW-1:0] clr_cnt;
  clr_t        clr;
  logic [EW-1:0] echo_ptr;
  logic [SW-1:0] sweep_ptr;
  lane_stat_t  stat_l, stat_r;
  logic [7:0]  out_l, out_r;
  logic        start;
  logic        take;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !clearing && stat_l.idle && stat_r.idle;
  assign start         = s_axis_tvalid && s_axis_tready;
  // merge: both lanes finished and the output register is free
  assign take          = stat_l.done && stat_r.done && (!m_axis_tvalid || m_axis_tready);
  assign clr.en        = clearing;
  assign clr.addr      = CLR_AW'(clr_cnt);

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bass_gain     <= 16'd32768;
      cfg.mid_gain      <= 16'd3277;
      cfg.treble_gain   <= 16'd32768;
      cfg.echo_mix      <= 16'd6554;
      cfg.echo_feedback <= 16'd13107;
      cfg.lfo_step      <= 20'd102535;
      cfg.sweep_depth   <= 11'd700;
      cfg.chorus_mix    <= 16'd16384;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BASS_GAIN:     cfg.bass_gain     <= cfg_data[15:0];
        REG_MID_GAIN:      cfg.mid_gain      <= cfg_data[15:0];
        REG_TREBLE_GAIN:   cfg.treble_gain   <= cfg_data[15:0];
        REG_ECHO_MIX:      cfg.echo_mix      <= cfg_data[15:0];
        REG_ECHO_FEEDBACK: cfg.echo_feedback <= cfg_data[15:0];
        REG_LFO_STEP:      cfg.lfo_step      <= cfg_data;
        REG_SWEEP_DEPTH:   cfg.sweep_depth   <= cfg_data[10:0];
        REG_CHORUS_MIX:    cfg.chorus_mix    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Post-reset memory sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      if (clr_cnt == CW'(CLR_DEPTH - 1)) clearing <= 1'b0;
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Shared delay pointers advance once per delivered frame
  always_ff @(posedge clk) begin
    if (rst) begin
      echo_ptr  <= '0;
      sweep_ptr <= '0;
    end else if (take) begin
      echo_ptr  <= (echo_ptr == EW'(ECHO_SAMPLES - 1)) ? '0 : echo_ptr + 1'b1;
      sweep_ptr <= (sweep_ptr == SW'(SWEEP_SAMPLES - 1)) ? '0 : sweep_ptr + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) m_axis_tdata <= {out_r, out_l};
  end

  sec_lane #(
    .ECHO_SAMPLES (ECHO_SAMPLES),
    .SWEEP_SAMPLES(SWEEP_SAMPLES),
    .SINE_DEPTH   (SINE_DEPTH),
    .PHASE_A_INIT (32'h0000_0000)
  ) u_lane_l (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .clr       (clr),
    .start     (start),
    .sample_in (s_axis_tdata[7:0]),
    .ep        (echo_ptr),
    .sp        (sweep_ptr),
    .take      (take),
    .stat      (stat_l),
    .sample_out(out_l)
  );

  sec_lane #(
    .ECHO_SAMPLES (ECHO_SAMPLES),
    .SWEEP_SAMPLES(SWEEP_SAMPLES),
    .SINE_DEPTH   (SINE_DEPTH),
    .PHASE_A_INIT (32'h8000_0000)
  ) u_lane_r (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .clr       (clr),
    .start     (start),
    .sample_in (s_axis_tdata[15:8]),
    .ep        (echo_ptr),
    .sp        (sweep_ptr),
    .take      (take),
    .stat      (stat_r),
    .sample_out(out_r)
  );

`ifndef SYNTHESIS
  a_no_input_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_axis_tready) else $error("input taken during memory sweep");

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    (stat_l.done == stat_r.done) && (stat_l.idle == stat_r.idle))
    else $error("channel lanes out of step");

  a_ptr_moves_on_take: assert property (@(posedge clk) disable iff (rst)
    !$stable(echo_ptr) |-> $past(take)) else $error("echo pointer moved without a frame");

  a_take_loads_output: assert property (@(posedge clk) disable iff (rst)
    take |=> m_axis_tvalid) else $error("finished frame not presented");
`endif

endmodule

`default_nettype wire

### design/sec_lane.sv
// sec_lane: one channel of the EQ / echo / chorus chain, a sequencer around
// one shared multiplier with its own echo and chorus memories. Uses sec_pkg.
`default_nettype none

module sec_lane #(
  parameter int          ECHO_SAMPLES  = sec_pkg::ECHO_SAMPLES_DEF,
  parameter int          SWEEP_SAMPLES = sec_pkg::SWEEP_SAMPLES_DEF,
  parameter int          SINE_DEPTH    = sec_pkg::SINE_DEPTH_DEF,
  parameter logic [31:0] PHASE_A_INIT  = 32'h0,
  parameter int          EW = (ECHO_SAMPLES > 1) ? $clog2(ECHO_SAMPLES) : 1,
  parameter int          SW = $clog2(SWEEP_SAMPLES)
) (
  input  wire                      clk,
  input  wire                      rst,
  input  sec_pkg::cfg_t            cfg,
  input  sec_pkg::clr_t            clr,
  input  wire                      start,
  input  wire  [7:0]               sample_in,
  input  wire  [EW-1:0]            ep,
  input  wire  [SW-1:0]            sp,
  input  wire                      take,
  output sec_pkg::lane_stat_t      stat,
  output logic [7:0]               sample_out
);
  import sec_pkg::*;

  localparam int TW        = $clog2(SINE_DEPTH);
  localparam int DEPTH_LIM = SWEEP_SAMPLES - 201;

  typedef logic signed [15:0] sine_tab_t [SINE_DEPTH];

  function automatic sine_tab_t build_sine();
    sine_tab_t t;
    longint unsigned turn;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      turn = (longint'(i) << 32) / SINE_DEPTH;
      t[i] = sine_of(turn[31:0]);
    end
    return t;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  lane_state_t state, state_next;

  logic signed [24:0] s_val;
  logic signed [31:0] low;
  logic signed [31:0] high;
  logic signed [55:0] acc;
  logic signed [60:0] prod;
  logic signed [23:0] x;
  logic signed [23:0] d;
  logic signed [23:0] tap1;
  logic signed [23:0] tap2;
  logic signed [23:0] sweep_rd;
  logic signed [15:0] sine_rd;
  logic [31:0]        phase_a;
  logic [31:0]        phase_b;

  logic signed [23:0] echo_mem  [ECHO_SAMPLES];
  logic signed [23:0] sweep_mem [SWEEP_SAMPLES];

  logic signed [35:0] mul_a;
  logic signed [24:0] mul_b;

  logic signed [33:0] diff_low;
  logic signed [33:0] mid;
  logic [14:0]        depth_sat;
  logic [15:0]        lfo;
  logic [SW:0]        delay;
  logic [SW+1:0]      pos_raw;
  logic [SW-1:0]      pos;
  logic signed [23:0] chor;
  logic signed [17:0] dry_gain;
  logic signed [24:0] out_biased;
  logic [TW-1:0]      tab_idx;

  assign diff_low = 34'(s_val) - 34'(low);
  assign mid      = 34'(s_val) - 34'(low) - 34'(high);
  assign depth_sat = (15'(cfg.sweep_depth) > 15'(DEPTH_LIM)) ? 15'(DEPTH_LIM)
                                                            : 15'(cfg.sweep_depth);
  assign lfo      = 16'(17'(sine_rd) + 17'sd32768);
  assign delay    = (SW+1)'(TAP_BASE) + (SW+1)'(prod >>> 16);
  assign pos_raw  = (SW+2)'(sp) + (SW+2)'(SWEEP_SAMPLES) - (SW+2)'(delay);
  assign pos      = (pos_raw >= (SW+2)'(SWEEP_SAMPLES))
                    ? SW'(pos_raw - (SW+2)'(SWEEP_SAMPLES)) : SW'(pos_raw);
  assign chor     = 24'((25'(tap1) + 25'(tap2)) >>> 1);
  assign dry_gain = 18'sd32768 - $signed(18'(cfg.chorus_mix));
  assign tab_idx  = prod[32 +: TW];
  assign out_biased = 25'(x) + 25'sd32768;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (start) state_next = ST_LOW_MUL;
      ST_LOW_MUL:  state_next = ST_LOW_ADD;
      ST_LOW_ADD:  state_next = ST_HIGH_UPD;
      ST_HIGH_UPD: state_next = ST_BASS_MUL;
      ST_BASS_MUL: state_next = ST_MID_MUL;
      ST_MID_MUL:  state_next = ST_TREB_MUL;
      ST_TREB_MUL: state_next = ST_EQ_SUM;
      ST_EQ_SUM:   state_next = ST_EQ_SAT;
      ST_EQ_SAT:   state_next = ST_ECHO_MIX;
      ST_ECHO_MIX: state_next = ST_ECHO_WR;
      ST_ECHO_WR:  state_next = ST_IDX_A;
      ST_IDX_A:    state_next = ST_LFO_A;
      ST_LFO_A:    state_next = ST_TAP_A;
      ST_TAP_A:    state_next = ST_IDX_B;
      ST_IDX_B:    state_next = ST_LFO_B;
      ST_LFO_B:    state_next = ST_TAP_B;
      ST_TAP_B:    state_next = ST_STEP_B;
      ST_STEP_B:   state_next = ST_CHOR_DRY;
      ST_CHOR_DRY: state_next = ST_CHOR_WET;
      ST_CHOR_WET: state_next = ST_CHOR_SUM;
      ST_CHOR_SUM: state_next = ST_DONE;
      ST_DONE:     if (take) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Multiplier operand select, status outputs and output byte clamp
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_LOW_MUL:  begin mul_a = 36'(diff_low); mul_b = 25'(LOW_WEIGHT); end
      ST_BASS_MUL: begin mul_a = 36'(low);  mul_b = $signed(25'(cfg.bass_gain)); end
      ST_MID_MUL:  begin mul_a = 36'(mid);  mul_b = $signed(25'(cfg.mid_gain)); end
      ST_TREB_MUL: begin mul_a = 36'(high); mul_b = $signed(25'(cfg.treble_gain)); end
      ST_EQ_SAT:   begin mul_a = 36'(d);    mul_b = $signed(25'(cfg.echo_mix)); end
      ST_ECHO_MIX: begin mul_a = 36'(d);    mul_b = $signed(25'(cfg.echo_feedback)); end
      ST_ECHO_WR:  begin mul_a = $signed(36'(phase_a)); mul_b = 25'(SINE_DEPTH); end
      ST_LFO_A:    begin mul_a = $signed(36'(lfo)); mul_b = $signed(25'(depth_sat)); end
      ST_TAP_A:    begin mul_a = $signed(36'(phase_b)); mul_b = 25'(SINE_DEPTH); end
      ST_LFO_B:    begin mul_a = $signed(36'(lfo)); mul_b = $signed(25'(depth_sat)); end
      ST_TAP_B:    begin mul_a = $signed(36'(cfg.lfo_step)); mul_b = 25'sd7; end
      ST_STEP_B:   begin mul_a = 36'(prod); mul_b = 25'(DIV10_RECIP); end
      ST_CHOR_DRY: begin mul_a = 36'(x);    mul_b = 25'(dry_gain); end
      ST_CHOR_WET: begin mul_a = 36'(chor); mul_b = $signed(25'(cfg.chorus_mix)); end
      default:     begin mul_a = '0; mul_b = '0; end
    endcase
    stat.idle = (state == ST_IDLE);
    stat.done = (state == ST_DONE);
    if (out_biased < 0) sample_out = 8'd0;
    else if ((out_biased >>> 8) > 25'sd255) sample_out = 8'd255;
    else sample_out = out_biased[15:8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      low     <= '0;
      high    <= '0;
      phase_a <= PHASE_A_INIT;
      phase_b <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_LOW_ADD:  low  <= low + 32'(prod >>> 16);
        ST_HIGH_UPD: high <= high + 32'(mid >>> 3);
        ST_STEP_B:   phase_a <= phase_a + 32'(cfg.lfo_step);
        ST_CHOR_DRY: phase_b <= phase_b + 32'(prod >>> DIV10_SHIFT);
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      ST_IDLE:     if (start) s_val <= 25'($signed({1'b0, sample_in}) - 10'sd128) <<< 16;
      ST_MID_MUL:  acc <= 56'(prod);
      ST_TREB_MUL: acc <= acc + 56'(prod);
      ST_EQ_SUM:   acc <= acc + 56'(prod);
      ST_EQ_SAT:   x <= sat24(64'(acc >>> 23));
      ST_ECHO_MIX: x <= sat24(64'(x) + 64'(prod >>> 15));
      ST_IDX_A:    sine_rd <= SINE_TAB[tab_idx];
      ST_IDX_B:    begin sine_rd <= SINE_TAB[tab_idx]; tap1 <= sweep_rd; end
      ST_STEP_B:   tap2 <= sweep_rd;
      ST_CHOR_WET: acc <= 56'(prod);
      ST_CHOR_SUM: x <= sat24(64'((62'(acc) + 62'(prod)) >>> 15));
      default: ;
    endcase
  end

  // Echo memory: read at frame start, written back once per frame
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) d <= echo_mem[ep];
    if (clr.en) begin
      if (32'(clr.addr) < ECHO_SAMPLES) echo_mem[EW'(clr.addr)] <= '0;
    end else if (state == ST_ECHO_WR) begin
      echo_mem[ep] <= sat24(64'(x) + 64'(prod >>> 15));
    end
  end

  // Chorus memory: write current sample, then read the two swept taps
  always_ff @(posedge clk) begin
    if (state == ST_TAP_A || state == ST_TAP_B) sweep_rd <= sweep_mem[pos];
    if (clr.en) begin
      if (32'(clr.addr) < SWEEP_SAMPLES) sweep_mem[SW'(clr.addr)] <= '0;
    end else if (state == ST_ECHO_WR) begin
      sweep_mem[sp] <= x;
    end
  end

endmodule

`default_nettype wire

### tb/sv/sec_scoreboard.sv
// sec_scoreboard: watches the cfg, s_axis and m_axis channels of
// stereo_eq_reverb_chorus, predicts each output frame and compares it.
// Depends on sec_pkg for the register index names.
module sec_scoreboard (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_axis_tvalid,
  input  wire        s_axis_tready,
  input  wire [15:0] s_axis_tdata,
  input  wire        m_axis_tvalid,
  input  wire        m_axis_tready,
  input  wire [15:0] m_axis_tdata,
  input  wire        cfg_valid,
  input  wire        cfg_ready,
  input  wire [3:0]  cfg_index,
  input  wire [19:0] cfg_data,
  output int         errors,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import sec_pkg::*;

  localparam int ECHO_LEN  = 11025;
  localparam int SWEEP_LEN = 2205;
  localparam int ROM_LEN   = 1024;
  localparam int MAX_SWING = SWEEP_LEN - 201;

  logic [15:0] g_bass, g_mid, g_treb, e_mix, e_fb, c_mix;
  logic [19:0] l_step;
  logic [10:0] s_depth;

  int          low_lvl [2];
  int          high_lvl[2];
  logic signed [23:0] echo_mem [2][ECHO_LEN];
  logic signed [23:0] sweep_mem[2][SWEEP_LEN];
  int          echo_ptr, sweep_ptr;
  logic [31:0] phase_a[2], phase_b[2];
  int          sine_tab[ROM_LEN];
  logic [15:0] frames_due[$];

  function automatic longint clip24(input longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  // fifth-order quadrant polynomial, Q1.15
  function automatic int poly_sine(input logic [31:0] turn);
    longint unsigned z, z2, r, y;
    z = (turn & 32'h3FFF_FFFF) >> 14;
    if (turn[30]) z = 65536 - z;
    z2 = (z * z) >> 16;
    r = 41906 - ((4569 * z2) >> 16);
    r = 102873 - ((r * z2) >> 16);
    y = ((r * z) >> 16) >> 1;
    if (y > 32767) y = 32767;
    return turn[31] ? -int'(y) : int'(y);
  endfunction

  function automatic int tap_index(input logic [31:0] phase, input longint depth);
    longint lfo, dly, pos;
    lfo = sine_tab[phase[31:22]] + 32768;
    dly = 200 + ((lfo * depth) >>> 16);
    pos = sweep_ptr + SWEEP_LEN - dly;
    if (pos >= SWEEP_LEN) pos -= SWEEP_LEN;
    return int'(pos);
  endfunction

  // one channel through EQ, echo and chorus; returns the output byte
  function automatic logic [7:0] shape_sample(input int ch, input logic [7:0] raw);
    longint s, low, high, mid, acc, x, d, chor, depth;
    int p1, p2;
    s = (longint'(raw) - 128) * 65536;
    low = low_lvl[ch];
    low += ((s - low) * 655) >>> 16;
    low_lvl[ch] = int'(low);
    high = high_lvl[ch];
    high += (((s - low) - high) * 8192) >>> 16;
    high_lvl[ch] = int'(high);
    mid = s - low - high;
    acc = low * longint'(g_bass) + mid * longint'(g_mid) + high * longint'(g_treb);
    x = clip24(acc >>> 23);
    // feedback delay
    d = echo_mem[ch][echo_ptr];
    x = clip24(x + ((d * longint'(e_mix)) >>> 15));
    echo_mem[ch][echo_ptr] = 24'(clip24(x + ((d * longint'(e_fb)) >>> 15)));
    // chorus: dry write first, then the two swept taps
    sweep_mem[ch][sweep_ptr] = 24'(x);
    depth = (s_depth > MAX_SWING) ? MAX_SWING : s_depth;
    p1 = tap_index(phase_a[ch], depth);
    p2 = tap_index(phase_b[ch], depth);
    chor = (longint'(sweep_mem[ch][p1]) + longint'(sweep_mem[ch][p2])) >>> 1;
    x = clip24((x * (32768 - longint'(c_mix)) + chor * longint'(c_mix)) >>> 15);
    phase_a[ch] += 32'(l_step);
    phase_b[ch] += 32'((longint'(l_step) * 7) / 10);
    x += 32768;
    if (x < 0) return 8'd0;
    x = x >>> 8;
    return (x > 255) ? 8'd255 : 8'(x);
  endfunction

  initial begin
    for (int i = 0; i < ROM_LEN; i++)
      sine_tab[i] = poly_sine(32'((longint'(i) << 32) / ROM_LEN));
  end

  always @(posedge clk) begin
    logic [7:0] l_o, r_o;
    logic [15:0] want;
    if (rst) begin
      g_bass <= 32768; g_mid <= 3277; g_treb <= 32768;
      e_mix <= 6554; e_fb <= 13107; l_step <= 102535;
      s_depth <= 700; c_mix <= 16384;
      low_lvl = '{0, 0};
      high_lvl = '{0, 0};
      for (int c = 0; c < 2; c++) begin
        for (int i = 0; i < ECHO_LEN; i++) echo_mem[c][i] = '0;
        for (int i = 0; i < SWEEP_LEN; i++) sweep_mem[c][i] = '0;
      end
      echo_ptr = 0;
      sweep_ptr = 0;
      phase_a = '{32'h0, 32'h8000_0000};
      phase_b = '{32'h0, 32'h0};
      frames_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BASS_GAIN:     g_bass  <= cfg_data[15:0];
          REG_MID_GAIN:      g_mid   <= cfg_data[15:0];
          REG_TREBLE_GAIN:   g_treb  <= cfg_data[15:0];
          REG_ECHO_MIX:      e_mix   <= cfg_data[15:0];
          REG_ECHO_FEEDBACK: e_fb    <= cfg_data[15:0];
          REG_LFO_STEP:      l_step  <= cfg_data;
          REG_SWEEP_DEPTH:   s_depth <= cfg_data[10:0];
          REG_CHORUS_MIX:    c_mix   <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        l_o = shape_sample(0, s_axis_tdata[7:0]);
        r_o = shape_sample(1, s_axis_tdata[15:8]);
        frames_due.push_back({r_o, l_o});
        echo_ptr = (echo_ptr + 1 >= ECHO_LEN) ? 0 : echo_ptr + 1;
        sweep_ptr = (sweep_ptr + 1 >= SWEEP_LEN) ? 0 : sweep_ptr + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (frames_due.size() == 0) begin
          $display("%t: unexpected output frame %h", $realtime, m_axis_tdata);
          errors++;
        end else begin
          want = frames_due.pop_front();
          if (m_axis_tdata[7:0] !== want[7:0]) begin
            $display("%t: left_out expected %0d actual %0d", $realtime,
                     want[7:0], m_axis_tdata[7:0]);
            errors++;
          end
          if (m_axis_tdata[15:8] !== want[15:8]) begin
            $display("%t: right_out expected %0d actual %0d", $realtime,
                     want[15:8], m_axis_tdata[15:8]);
            errors++;
          end
        end
      end
    end
    pending = frames_due.size();
  end
endmodule

### tb/sv/tb_stereo_eq_reverb_chorus.sv
// tb_stereo_eq_reverb_chorus: stimulus and verdict for the stereo EQ /
// echo / chorus block. Depends on sec_pkg, the block and sec_scoreboard.
module tb_stereo_eq_reverb_chorus;
  timeunit 1ns;
  timeprecision 1ps;
  import sec_pkg::*;

  // index past the register file; the block must ignore it
  localparam logic [3:0] REG_UNUSED = 4'd15;
  localparam int SETTLE = 40;   // a margin over the lane latency

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  wire         s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [7:0] left_in, [15:8] right_in
  wire         m_axis_tvalid;
  logic        m_axis_tready = 0;
  wire  [15:0] m_axis_tdata;        // [7:0] left_out, [15:8] right_out
  logic        cfg_valid = 0;
  wire         cfg_ready;
  logic [3:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;

  int errors, pending;
  bit no_gaps = 0;      // run both sides flat out
  bit hold_req = 0;     // ask the sink for one long hold-off

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  stereo_eq_reverb_chorus uut (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  sec_scoreboard chk (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .errors, .pending
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // leaves cfg_valid high; caller drops it after the last beat
  task automatic cfg_beat(input logic [3:0] idx, input logic [19:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_regs(input logic [15:0] bass, mid, treb, emix, efb,
                           input logic [19:0] step, input logic [10:0] depth,
                           input logic [15:0] cmix);
    cfg_beat(REG_BASS_GAIN, bass);
    cfg_beat(REG_MID_GAIN, mid);
    cfg_beat(REG_TREBLE_GAIN, treb);
    cfg_beat(REG_ECHO_MIX, emix);
    cfg_beat(REG_ECHO_FEEDBACK, efb);
    cfg_beat(REG_LFO_STEP, step);
    cfg_beat(REG_SWEEP_DEPTH, depth);
    cfg_beat(REG_CHORUS_MIX, cmix);
    cfg_valid <= 0;
  endtask

  task automatic send_frame(input logic [7:0] left, right);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {right, left};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // random audio: mostly noise, some full-scale square bursts to push
  // the filters and delay lines into saturation; leaves tvalid high
  task automatic send_random(input int count);
    int burst;
    bit hi;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0 && $urandom_range(0, 9) < 2) burst = $urandom_range(4, 30);
      if (burst > 0) begin
        burst--;
        hi = $urandom_range(0, 1);
        send_frame(hi ? 8'd255 : 8'd0, hi ? 8'd0 : 8'd255);
      end else begin
        send_frame(8'($urandom), 8'($urandom));
      end
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // sink: random ready, one long hold-off on request so the block backs up
  initial begin
    int gap;
    wait (!rst);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        m_axis_tready <= 0;
        repeat (500) @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          m_axis_tready <= 0;
          repeat (gap) @(posedge clk);
        end
      end
      m_axis_tready <= 1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin
    #10ms;
    $display("** stereo_eq_reverb_chorus: FAILED **");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;

    // defaults: silence, rails, alternating extremes
    send_frame(8'd128, 8'd128);
    send_frame(8'd0, 8'd255);
    send_frame(8'd255, 8'd0);
    send_frame(8'd0, 8'd0);
    repeat (4) send_frame(8'd255, 8'd255);
    repeat (4) send_frame(8'd0, 8'd0);
    for (int i = 0; i < 8; i++) send_frame(i[0] ? 8'd255 : 8'd0, i[0] ? 8'd0 : 8'd255);
    send_frame(8'd127, 8'd129);
    send_frame(8'd128, 8'd128);
    no_gaps = 1;
    send_random(60);
    no_gaps = 0;
    hold_req = 1;   // sink stalls while the source keeps pushing
    send_random(70);
    drain();

    // write to an unused index, then everything pegged: gains near two,
    // negative dry share, deepest swing, fastest LFO
    cfg_beat(REG_UNUSED, 20'hFFFFF);
    load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              20'hFFFFF, 11'h7FF, 16'hFFFF);
    send_random(135);
    drain();

    // everything off
    load_regs('0, '0, '0, '0, '0, '0, '0, '0);
    send_random(135);
    drain();

    // top of the nominal ranges
    load_regs(16'd32768, 16'd32768, 16'd32768, 16'd32768, 16'd32768,
              20'd683565, 11'd2004, 16'd32768);
    send_random(135);
    drain();

    for (int p = 0; p < 3; p++) begin
      load_regs(16'($urandom), 16'($urandom_range(0, 32768)), 16'($urandom),
                16'($urandom_range(0, 40000)), 16'($urandom_range(0, 40000)),
                20'($urandom), 11'($urandom), 16'($urandom));
      no_gaps = (p == 1);
      send_random(135);
      drain();
    end
    no_gaps = 0;

    if (errors == 0) begin
      $display("** stereo_eq_reverb_chorus: PASSED **");
    end else begin
      $display("** stereo_eq_reverb_chorus: FAILED **");
    end
    $finish;
  end
endmodule
